// ===== rtl/core/asam_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asam_pkg: shared types and constants of the affine address map
// Field widths, configuration register codes and the structs that travel
// between the configuration block and the pipeline stages.
// ----------------------------------------------------------------------------
package asam_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned DIM_W      = 13;
  localparam int unsigned COEF_W     = 32;
  localparam int unsigned INDEX_W    = 24;
  localparam int unsigned CFG_IDX_W  = 3;

  // Internal datapath widths.
  // A centred coordinate lies in -2048..4095, the products stay below 2^43
  // in magnitude and the sum of two products plus the centre offset stays
  // below 2^45 for every supported fraction width.
  localparam int unsigned DELTA_W    = 14;
  localparam int unsigned PROD_W     = COEF_W + DELTA_W;
  localparam int unsigned ACC_W      = 48;
  localparam int unsigned IDX_FULL_W = 2 * DIM_W;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_COEF_XX      = 3'd2,
    REG_COEF_XY      = 3'd3,
    REG_COEF_YX      = 3'd4,
    REG_COEF_YY      = 3'd5
  } cfg_reg_e;

  // Configuration as seen by the datapath: clamped dimensions and halves.
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  half_w;
    logic [DIM_W-1:0]  half_h;
    logic [COEF_W-1:0] coef_xx;
    logic [COEF_W-1:0] coef_xy;
    logic [COEF_W-1:0] coef_yx;
    logic [COEF_W-1:0] coef_yy;
  } cfg_t;

  // Transformed coordinate pair handed from the transform to the address stages.
  typedef struct packed {
    logic             valid;
    logic [ACC_W-1:0] tx;
    logic [ACC_W-1:0] ty;
  } xform_t;

endpackage

// ===== rtl/core/asam_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asam_cfg: configuration registers
// Holds image size and matrix coefficients, clamps the dimensions and
// derives the integer image centre.
// ----------------------------------------------------------------------------
module asam_cfg #(
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asam_pkg::COEF_W-1:0]    cfg_data_i,
  output asam_pkg::cfg_t                 cfg_o
);

  logic [asam_pkg::DIM_W-1:0]  width_q, height_q;
  logic [asam_pkg::COEF_W-1:0] coef_xx_q, coef_xy_q, coef_yx_q, coef_yy_q;
  logic [asam_pkg::DIM_W-1:0]  width_c, height_c;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;

  // Register file; an index beyond the list is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= asam_pkg::DIM_W'(4096);
      height_q  <= asam_pkg::DIM_W'(4096);
      coef_xx_q <= asam_pkg::COEF_W'(65536);
      coef_xy_q <= '0;
      coef_yx_q <= '0;
      coef_yy_q <= asam_pkg::COEF_W'(65536);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        asam_pkg::REG_IMAGE_WIDTH:  width_q   <= cfg_data_i[asam_pkg::DIM_W-1:0];
        asam_pkg::REG_IMAGE_HEIGHT: height_q  <= cfg_data_i[asam_pkg::DIM_W-1:0];
        asam_pkg::REG_COEF_XX:      coef_xx_q <= cfg_data_i;
        asam_pkg::REG_COEF_XY:      coef_xy_q <= cfg_data_i;
        asam_pkg::REG_COEF_YX:      coef_yx_q <= cfg_data_i;
        asam_pkg::REG_COEF_YY:      coef_yy_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Dimensions above the supported maximum are clamped to it.
  assign width_c  = (32'(width_q) > MAX_DIM) ? asam_pkg::DIM_W'(MAX_DIM) : width_q;
  assign height_c = (32'(height_q) > MAX_DIM) ? asam_pkg::DIM_W'(MAX_DIM) : height_q;

  assign cfg_o.width   = width_c;
  assign cfg_o.height  = height_c;
  assign cfg_o.half_w  = width_c >> 1;
  assign cfg_o.half_h  = height_c >> 1;
  assign cfg_o.coef_xx = coef_xx_q;
  assign cfg_o.coef_xy = coef_xy_q;
  assign cfg_o.coef_yx = coef_yx_q;
  assign cfg_o.coef_yy = coef_yy_q;

endmodule

// ===== rtl/core/asam_xform.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asam_xform: centring, matrix multiply and accumulate
// Three pipeline stages: centre the destination coordinate, form the four
// products, then sum each row with the centre offset in fixed point.
// ----------------------------------------------------------------------------
module asam_xform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  asam_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [asam_pkg::COORD_W-1:0] dest_x_i,
  input  logic [asam_pkg::COORD_W-1:0] dest_y_i,
  output asam_pkg::xform_t             xf_o,
  input  logic                         down_ready_i
);

  localparam int unsigned DW = asam_pkg::DELTA_W;
  localparam int unsigned PW = asam_pkg::PROD_W;
  localparam int unsigned AW = asam_pkg::ACC_W;

  logic                 en1, en2, en3;
  logic                 v1_q, v2_q, v3_q;
  logic signed [DW-1:0] dx1_q, dy1_q, dx_d, dy_d;
  logic signed [PW-1:0] pxx_q, pxy_q, pyx_q, pyy_q;
  logic signed [AW-1:0] tx_q, ty_q, tx_d, ty_d;
  logic signed [AW-1:0] bias_x, bias_y;

  // A stage advances when it is empty or the next stage advances.
  assign en3        = !v3_q || down_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  // Stage 1: centre on the integer image halves.
  assign dx_d = $signed(DW'(dest_x_i)) - $signed(DW'(cfg_i.half_w));
  assign dy_d = $signed(DW'(dest_y_i)) - $signed(DW'(cfg_i.half_h));

  // Stage 3 inputs: the centre moved into the fixed-point domain.
  assign bias_x = $signed(AW'(cfg_i.half_w) << FRAC_BITS);
  assign bias_y = $signed(AW'(cfg_i.half_h) << FRAC_BITS);
  assign tx_d   = AW'(pxx_q) + AW'(pxy_q) + bias_x;
  assign ty_d   = AW'(pyx_q) + AW'(pyy_q) + bias_y;

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  // Payload registers of the three stages.
  always_ff @(posedge clk_i) begin
    if (en1) begin
      dx1_q <= dx_d;
      dy1_q <= dy_d;
    end
    if (en2) begin
      pxx_q <= $signed(cfg_i.coef_xx) * dx1_q;
      pxy_q <= $signed(cfg_i.coef_xy) * dy1_q;
      pyx_q <= $signed(cfg_i.coef_yx) * dx1_q;
      pyy_q <= $signed(cfg_i.coef_yy) * dy1_q;
    end
    if (en3) begin
      tx_q <= tx_d;
      ty_q <= ty_d;
    end
  end

  assign xf_o.valid = v3_q;
  assign xf_o.tx    = tx_q;
  assign xf_o.ty    = ty_q;

endmodule

// ===== rtl/core/asam_addr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asam_addr: truncation, bounds test and linear index
// Two pipeline stages: truncate toward zero and test against the image,
// then form the linear pixel index into the output register.
// ----------------------------------------------------------------------------
module asam_addr #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  asam_pkg::cfg_t               cfg_i,
  input  asam_pkg::xform_t             xf_i,
  output logic                         up_ready_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [asam_pkg::COORD_W-1:0] source_x_o,
  output logic [asam_pkg::COORD_W-1:0] source_y_o,
  output logic [asam_pkg::INDEX_W-1:0] source_index_o,
  output logic                         inside_res_o
);

  localparam int unsigned AW = asam_pkg::ACC_W;
  localparam int unsigned SW = AW - FRAC_BITS;
  localparam int unsigned NW = asam_pkg::DIM_W;
  localparam int unsigned IW = asam_pkg::IDX_FULL_W;
  localparam logic [AW-1:0] RND = AW'((64'd1 << FRAC_BITS) - 64'd1);

  logic          en4, en5;
  logic          v4_q, v5_q;
  logic [AW-1:0] tbx, tby;
  logic [SW-1:0] sx, sy;
  logic          in_x, in_y, inside_d;
  logic [NW-1:0] sx4_q, sy4_q;
  logic          inside4_q;
  logic [IW-1:0] idx_d;
  logic [asam_pkg::COORD_W-1:0] sx5_q, sy5_q;
  logic [asam_pkg::INDEX_W-1:0] idx5_q;
  logic          inside5_q;

  // Output register frees when it is empty or its transaction completes.
  assign en5        = !v5_q || !out_stall_i;
  assign en4        = !v4_q || en5;
  assign up_ready_o = en4;

  // Stage 4: a negative value is biased up first so the shift rounds toward zero.
  assign tbx = xf_i.tx + (xf_i.tx[AW-1] ? RND : '0);
  assign tby = xf_i.ty + (xf_i.ty[AW-1] ? RND : '0);
  assign sx  = tbx[AW-1:FRAC_BITS];
  assign sy  = tby[AW-1:FRAC_BITS];

  // Bounds test against the clamped image size.
  assign in_x     = !sx[SW-1] && (sx < SW'(cfg_i.width));
  assign in_y     = !sy[SW-1] && (sy < SW'(cfg_i.height));
  assign inside_d = in_x && in_y;

  // Stage 5: linear index of the source pixel.
  assign idx_d = IW'(sy4_q) * IW'(cfg_i.width) + IW'(sx4_q);

  // Valid bits of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (en4) v4_q <= xf_i.valid;
      if (en5) v5_q <= v4_q;
    end
  end

  // Payload registers; an outside source is carried as all zeros.
  always_ff @(posedge clk_i) begin
    if (en4) begin
      sx4_q     <= inside_d ? sx[NW-1:0] : '0;
      sy4_q     <= inside_d ? sy[NW-1:0] : '0;
      inside4_q <= inside_d;
    end
    if (en5) begin
      sx5_q     <= sx4_q[asam_pkg::COORD_W-1:0];
      sy5_q     <= sy4_q[asam_pkg::COORD_W-1:0];
      idx5_q    <= idx_d[asam_pkg::INDEX_W-1:0];
      inside5_q <= inside4_q;
    end
  end

  assign out_valid_o    = v5_q;
  assign source_x_o     = sx5_q;
  assign source_y_o     = sy5_q;
  assign source_index_o = idx5_q;
  assign inside_res_o   = inside5_q;

endmodule

// ===== rtl/core/affine_rotate_scale_address_map_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// affine_rotate_scale_address_map_unit: nearest-neighbor affine address map
// Maps an output pixel coordinate to the source pixel it copies.
// ----------------------------------------------------------------------------
// The block accepts one destination coordinate per clock while in_stall_o
// is low and returns its source coordinate, linear index and inside flag
// in order. The five-stage pipeline (centre, multiply, accumulate, truncate
// and bounds test, index) takes a new coordinate before the earlier ones
// have left it; each stage holds its transaction while the stage after it
// is full and held, so a result-side stall fills bubbles before it stops the
// input. Coefficients are signed fixed point with FRAC_BITS fraction bits;
// image dimensions above MAX_DIM are clamped. Configuration should be
// written only while no transaction is in flight.
module affine_rotate_scale_address_map_unit #(
  parameter int unsigned MAX_DIM   = 4096,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [asam_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [asam_pkg::COEF_W-1:0]    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [asam_pkg::COORD_W-1:0]   dest_x_i,
  input  logic [asam_pkg::COORD_W-1:0]   dest_y_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [asam_pkg::COORD_W-1:0]   source_x_o,
  output logic [asam_pkg::COORD_W-1:0]   source_y_o,
  output logic [asam_pkg::INDEX_W-1:0]   source_index_o,
  output logic                           inside_res_o
);

  asam_pkg::cfg_t   cfg;
  asam_pkg::xform_t xf;
  logic             in_ready;
  logic             addr_ready;

  // Configuration registers.
  asam_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Centring and matrix stages.
  asam_xform #(
    .FRAC_BITS (FRAC_BITS)
  ) u_xform (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready),
    .dest_x_i     (dest_x_i),
    .dest_y_i     (dest_y_i),
    .xf_o         (xf),
    .down_ready_i (addr_ready)
  );

  // Truncation, bounds and index stages.
  asam_addr #(
    .FRAC_BITS (FRAC_BITS)
  ) u_addr (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .xf_i           (xf),
    .up_ready_o     (addr_ready),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .source_x_o     (source_x_o),
    .source_y_o     (source_y_o),
    .source_index_o (source_index_o),
    .inside_res_o   (inside_res_o)
  );

  assign in_stall_o = !in_ready;

endmodule

// ===== rtl/core/asam_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asam_chk: port-level checker for the affine address map
// Watches the top-level ports for result integrity and pipeline occupancy.
// ----------------------------------------------------------------------------
module asam_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [asam_pkg::COORD_W-1:0]   source_x_o,
  input logic [asam_pkg::COORD_W-1:0]   source_y_o,
  input logic [asam_pkg::INDEX_W-1:0]   source_index_o,
  input logic                           inside_res_o
);

  localparam int unsigned DEPTH = 5;

  logic       in_acc, out_acc;
  logic [2:0] occ_q, occ_d;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;

  // Count transactions accepted but not yet delivered.
  always_comb begin
    occ_d = occ_q;
    if (in_acc && !out_acc) occ_d = occ_q + 3'd1;
    if (!in_acc && out_acc) occ_d = occ_q - 3'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(source_index_o)
      && $stable(source_x_o) && $stable(source_y_o) && $stable(inside_res_o)))
    else $error("stalled result changed");

  // An outside source reports all-zero coordinates and index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !inside_res_o) |->
      (source_x_o == '0 && source_y_o == '0 && source_index_o == '0))
    else $error("outside result carries nonzero fields");

  // No result without a pending transaction, and never more than the pipeline holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o |-> occ_q != 3'd0) && (occ_q <= 3'(DEPTH)))
    else $error("pipeline occupancy out of range");

  // An empty output register never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while output is empty");

endmodule

bind affine_rotate_scale_address_map_unit asam_chk u_asam_chk (.*);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the affine rotate/scale address map
// Walks a short table of directed pixels and register writes, then runs
// random phases with fresh matrices and image sizes. Every accepted pixel is
// mapped by an in-bench fixed-point predictor unless its result is typed in;
// the block's results are checked in order under random idling and stalls.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_DIM      = 4096;
  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned PIPE_LATENCY = 5;
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned NUM_PHASES   = 16;
  localparam int unsigned PHASE_PIXELS = 106;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned ERR_PRINTS   = 40;

  // Register indexes past the end of the list; writes to them are dropped.
  localparam logic [asam_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [asam_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [asam_pkg::COORD_W-1:0] sx;
    logic [asam_pkg::COORD_W-1:0] sy;
    logic [asam_pkg::INDEX_W-1:0] idx;
    logic                         in_img;
  } src_pixel_t;

  typedef enum logic [1:0] {
    ROW_WRITE,
    ROW_PIXEL,
    ROW_PIXEL_TYPED
  } row_kind_e;

  typedef struct packed {
    row_kind_e                      kind;
    logic [asam_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [asam_pkg::COEF_W-1:0]    data;
    logic [asam_pkg::COORD_W-1:0]   x;
    logic [asam_pkg::COORD_W-1:0]   y;
    src_pixel_t                     typed;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 39;

  // Directed table: register writes and pixels, some with results typed in.
  dir_row_t dir_table [DIR_ROWS] = '{
    // Reset matrix is the identity on a 4096 x 4096 image.
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b1}},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd4095, 12'd4095,
      '{12'd4095, 12'd4095, 24'd16777215, 1'b1}},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd1234, 12'd567,  '0},
    // A transformed coordinate just below zero truncates toward zero and stays inside.
    '{ROW_WRITE,       asam_pkg::REG_COEF_XX, 32'd65537, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b1}},
    // Coefficient extremes.
    '{ROW_WRITE,       asam_pkg::REG_COEF_XX, 32'h7fff_ffff, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_XY, 32'h8000_0000, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_YX, 32'h7fff_ffff, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_YY, 32'h8000_0000, 12'd0, 12'd0, '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd0,    12'd0,    '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd4095, 12'd0,    '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd0,    12'd4095, '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd2048, 12'd2047, '0},
    // Back to the identity.
    '{ROW_WRITE,       asam_pkg::REG_COEF_XX, 32'd65536, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_XY, 32'd0,     12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_YX, 32'd0,     12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_COEF_YY, 32'd65536, 12'd0, 12'd0, '0},
    // Zero width: nothing lies inside.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_WIDTH, 32'd0, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd100,  12'd100,  '{12'd0, 12'd0, 24'd0, 1'b0}},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b0}},
    // Width above the maximum is clamped to it.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_WIDTH, 32'd8191, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd4095, 12'd0,
      '{12'd4095, 12'd0, 24'd4095, 1'b1}},
    // Small image, last pixel inside and first column beyond it.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_WIDTH,  32'd100, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_HEIGHT, 32'd50,  12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd99,   12'd49,   '{12'd99, 12'd49, 24'd4999, 1'b1}},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd100,  12'd10,   '{12'd0, 12'd0, 24'd0, 1'b0}},
    // Half scale: an output pixel beyond the image still maps inside.
    '{ROW_WRITE,       asam_pkg::REG_COEF_XX, 32'd32768, 12'd0, 12'd0, '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd120,  12'd10,   '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd3000, 12'd4000, '0},
    // One by one image.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_WIDTH,  32'd1, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_HEIGHT, 32'd1, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b1}},
    // Writes past the register list change nothing.
    '{ROW_WRITE,       REG_SPARE_LO, 32'hffff_ffff, 12'd0, 12'd0, '0},
    '{ROW_WRITE,       REG_SPARE_HI, 32'h0000_0000, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b1}},
    // Zero height: nothing lies inside.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_HEIGHT, 32'd0, 12'd0, 12'd0, '0},
    '{ROW_PIXEL_TYPED, 3'd0, 32'd0, 12'd0,    12'd0,    '{12'd0, 12'd0, 24'd0, 1'b0}},
    // Full-height image one pixel wide at half horizontal scale.
    '{ROW_WRITE,       asam_pkg::REG_IMAGE_HEIGHT, 32'd4096, 12'd0, 12'd0, '0},
    '{ROW_PIXEL,       3'd0, 32'd0, 12'd7,    12'd3000, '0}
  };

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid_i;
  logic                           cfg_ready_o;
  logic [asam_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [asam_pkg::COEF_W-1:0]    cfg_data_i;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic [asam_pkg::COORD_W-1:0]   dest_x_i;
  logic [asam_pkg::COORD_W-1:0]   dest_y_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [asam_pkg::COORD_W-1:0]   source_x_o;
  logic [asam_pkg::COORD_W-1:0]   source_y_o;
  logic [asam_pkg::INDEX_W-1:0]   source_index_o;
  logic                           inside_res_o;

  // Shadow copy of the configuration registers.
  logic [asam_pkg::DIM_W-1:0]         map_width;
  logic [asam_pkg::DIM_W-1:0]         map_height;
  logic signed [asam_pkg::COEF_W-1:0] map_cxx;
  logic signed [asam_pkg::COEF_W-1:0] map_cxy;
  logic signed [asam_pkg::COEF_W-1:0] map_cyx;
  logic signed [asam_pkg::COEF_W-1:0] map_cyy;

  src_pixel_t  src_expected [$];
  int unsigned err_cnt;
  int unsigned cycle_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_go;
  bit          hold_done;
  int unsigned hold_cnt;

  affine_rotate_scale_address_map_unit #(
    .MAX_DIM  (MAX_DIM),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .dest_x_i      (dest_x_i),
    .dest_y_i      (dest_y_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .source_x_o    (source_x_o),
    .source_y_o    (source_y_o),
    .source_index_o(source_index_o),
    .inside_res_o  (inside_res_o)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Maps one output pixel to its source pixel with the shadow configuration.
  function automatic src_pixel_t map_source(logic [asam_pkg::COORD_W-1:0] px,
                                            logic [asam_pkg::COORD_W-1:0] py);
    longint     w;
    longint     h;
    longint     hw;
    longint     hh;
    longint     cx;
    longint     cy;
    longint     tx;
    longint     ty;
    longint     sx;
    longint     sy;
    longint     lin;
    longint     one;
    src_pixel_t r;
    one = longint'(1) << FRAC_BITS;
    w   = (map_width > MAX_DIM) ? longint'(MAX_DIM) : longint'(map_width);
    h   = (map_height > MAX_DIM) ? longint'(MAX_DIM) : longint'(map_height);
    hw  = w / 2;
    hh  = h / 2;
    cx  = longint'(px) - hw;
    cy  = longint'(py) - hh;
    tx  = longint'(map_cxx) * cx + longint'(map_cxy) * cy + hw * one;
    ty  = longint'(map_cyx) * cx + longint'(map_cyy) * cy + hh * one;
    // Integer division truncates toward zero, as the block does.
    sx  = tx / one;
    sy  = ty / one;
    r   = '0;
    if (sx >= 0 && sy >= 0 && sx < w && sy < h) begin
      lin      = sy * w + sx;
      r.sx     = sx[asam_pkg::COORD_W-1:0];
      r.sy     = sy[asam_pkg::COORD_W-1:0];
      r.idx    = lin[asam_pkg::INDEX_W-1:0];
      r.in_img = 1'b1;
    end
    return r;
  endfunction

  // Writes one register and mirrors the write in the shadow copy.
  task automatic write_reg(logic [asam_pkg::CFG_IDX_W-1:0] idx,
                           logic [asam_pkg::COEF_W-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      asam_pkg::REG_IMAGE_WIDTH:  map_width  = data[asam_pkg::DIM_W-1:0];
      asam_pkg::REG_IMAGE_HEIGHT: map_height = data[asam_pkg::DIM_W-1:0];
      asam_pkg::REG_COEF_XX:      map_cxx    = data;
      asam_pkg::REG_COEF_XY:      map_cxy    = data;
      asam_pkg::REG_COEF_YX:      map_cyx    = data;
      asam_pkg::REG_COEF_YY:      map_cyy    = data;
      default: ;
    endcase
  endtask

  // Ends a burst of register writes.
  task automatic end_writes();
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Waits until every expected result has come back and the pipeline is empty.
  task automatic drain();
    while (src_expected.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // Offers one pixel, with random idle cycles before it, until it is taken.
  task automatic send_pixel(logic [asam_pkg::COORD_W-1:0] px,
                            logic [asam_pkg::COORD_W-1:0] py, bit typed,
                            src_pixel_t typed_res);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    dest_x_i   <= px;
    dest_y_i   <= py;
    do @(posedge clk_i); while (in_stall_o);
    if (typed) src_expected.push_back(typed_res);
    else src_expected.push_back(map_source(px, py));
  endtask

  // Ends a stream of pixels.
  task automatic end_pixels();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  // Picks a coefficient: extremes, plain scales, zero, small values or anything.
  function automatic logic [asam_pkg::COEF_W-1:0] pick_coef();
    int signed v;
    case ($urandom_range(9))
      0: v = 32'sh7fff_ffff;
      1: v = 32'sh8000_0000;
      2: v = $urandom;
      3: v = 65536;
      4: v = -65536;
      5: v = 0;
      default: v = int'($urandom_range(262144)) - 131072;
    endcase
    return v;
  endfunction

  // Picks an image dimension, with random bits above the register width.
  function automatic logic [asam_pkg::COEF_W-1:0] pick_dim();
    logic [asam_pkg::COEF_W-1:0] d;
    d = $urandom;
    case ($urandom_range(11))
      0: d[asam_pkg::DIM_W-1:0] = ($urandom_range(3) == 0) ? 13'd0 : 13'd1;
      1: d[asam_pkg::DIM_W-1:0] = 13'd4096;
      2: d[asam_pkg::DIM_W-1:0] = asam_pkg::DIM_W'($urandom_range(8191, 4097));
      3: d[asam_pkg::DIM_W-1:0] = asam_pkg::DIM_W'($urandom_range(16, 1));
      default: d[asam_pkg::DIM_W-1:0] = asam_pkg::DIM_W'($urandom_range(4096, 2));
    endcase
    return d;
  endfunction

  // Compares one field of a result and reports a mismatch.
  task automatic check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      err_cnt++;
      if (err_cnt <= ERR_PRINTS)
        $display("%0t mismatch on %s: expected %0h, actual %0h", $realtime, what, exp_v, act_v);
    end
  endtask

  // Result checker: every result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    src_pixel_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (src_expected.size() == 0) begin
        err_cnt++;
        if (err_cnt <= ERR_PRINTS)
          $display("%0t unexpected result: expected none, actual %0h %0h %0h %0b", $realtime,
                   source_x_o, source_y_o, source_index_o, inside_res_o);
      end else begin
        e = src_expected.pop_front();
        check_field("source_x", 32'(e.sx), 32'(source_x_o));
        check_field("source_y", 32'(e.sy), 32'(source_y_o));
        check_field("source_index", 32'(e.idx), 32'(source_index_o));
        check_field("inside_res", 32'(e.in_img), 32'(inside_res_o));
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off counted here.
  initial begin
    out_stall_i = 1'b0;
    hold_done   = 1'b0;
    hold_cnt    = 0;
    forever begin
      @(negedge clk_i);
      if (!hold_go) begin
        hold_done = 1'b0;
        hold_cnt  = 0;
      end
      if (hold_go && !hold_done) begin
        out_stall_i <= 1'b1;
        hold_cnt++;
        if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Run limit.
  initial cycle_cnt = 0;
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Stimulus: reset, directed table, then random phases.
  initial begin
    logic [asam_pkg::COORD_W-1:0] px;
    logic [asam_pkg::COORD_W-1:0] py;
    int unsigned                  w_lim;
    int unsigned                  h_lim;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = '0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    dest_x_i       = '0;
    dest_y_i       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_go        = 1'b0;
    err_cnt        = 0;
    map_width      = 13'd4096;
    map_height     = 13'd4096;
    map_cxx        = 32'sd65536;
    map_cxy        = 32'sd0;
    map_cyx        = 32'sd0;
    map_cyy        = 32'sd65536;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part; a run of writes starts once the pipeline is empty.
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_WRITE) begin
        if (i == 0 || dir_table[i-1].kind != ROW_WRITE) begin
          end_pixels();
          drain();
        end
        write_reg(dir_table[i].reg_idx, dir_table[i].data);
        if (i + 1 < DIR_ROWS && dir_table[i+1].kind != ROW_WRITE) end_writes();
      end else begin
        send_pixel(dir_table[i].x, dir_table[i].y, dir_table[i].kind == ROW_PIXEL_TYPED,
                   dir_table[i].typed);
      end
    end
    end_pixels();

    // Random phases, each with its own configuration and idling pattern.
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      hold_go = 1'b0;
      if (ph == 0) begin
        write_reg(asam_pkg::REG_IMAGE_WIDTH, 32'd4096);
        write_reg(asam_pkg::REG_IMAGE_HEIGHT, 32'd4096);
        write_reg(asam_pkg::REG_COEF_XX, 32'h7fff_ffff);
        write_reg(asam_pkg::REG_COEF_XY, 32'h7fff_ffff);
        write_reg(asam_pkg::REG_COEF_YX, 32'h7fff_ffff);
        write_reg(asam_pkg::REG_COEF_YY, 32'h7fff_ffff);
      end else if (ph == 1) begin
        write_reg(asam_pkg::REG_IMAGE_WIDTH, 32'd1);
        write_reg(asam_pkg::REG_IMAGE_HEIGHT, 32'd1);
        write_reg(asam_pkg::REG_COEF_XX, 32'h8000_0000);
        write_reg(asam_pkg::REG_COEF_XY, 32'h8000_0000);
        write_reg(asam_pkg::REG_COEF_YX, 32'h8000_0000);
        write_reg(asam_pkg::REG_COEF_YY, 32'h8000_0000);
      end else begin
        write_reg(asam_pkg::REG_IMAGE_WIDTH, pick_dim());
        write_reg(asam_pkg::REG_IMAGE_HEIGHT, pick_dim());
        write_reg(asam_pkg::REG_COEF_XX, pick_coef());
        write_reg(asam_pkg::REG_COEF_XY, pick_coef());
        write_reg(asam_pkg::REG_COEF_YX, pick_coef());
        write_reg(asam_pkg::REG_COEF_YY, pick_coef());
        if ($urandom_range(3) == 0)
          write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      end
      end_writes();

      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 38; recv_stall_pct = 38; end
      endcase
      // One phase holds the result side off while pixels keep coming.
      if (ph == 2) hold_go = 1'b1;

      w_lim = (map_width == 0) ? 4096 :
              ((32'(map_width) > MAX_DIM) ? MAX_DIM : 32'(map_width));
      h_lim = (map_height == 0) ? 4096 :
              ((32'(map_height) > MAX_DIM) ? MAX_DIM : 32'(map_height));
      for (int unsigned n = 0; n < PHASE_PIXELS; n++) begin
        // Half the pixels fall in the output image, the rest anywhere.
        if ($urandom_range(1)) begin
          px = asam_pkg::COORD_W'($urandom_range(w_lim - 1));
          py = asam_pkg::COORD_W'($urandom_range(h_lim - 1));
        end else begin
          px = asam_pkg::COORD_W'($urandom);
          py = asam_pkg::COORD_W'($urandom);
        end
        send_pixel(px, py, 1'b0, '0);
      end
      end_pixels();
    end

    drain();
    hold_go = 1'b0;
    repeat (4 * PIPE_LATENCY) @(posedge clk_i);
    if (err_cnt == 0 && src_expected.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
